// ===== rtl/bfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bit field packer package
// Shared widths, opcodes and the structs passed between the packer modules.
// ----------------------------------------------------------------------------
package bfp_pkg;

	localparam int WORD_WIDTH_DEF = 32;
	localparam int DATA_W         = 32;
	localparam int LEN_W          = 6;
	localparam int OP_W           = 2;
	localparam int RAW_LEN_MAX    = 32;

	typedef enum logic [OP_W-1:0] {
		OP_RAW    = 2'd0,
		OP_RANGED = 2'd1,
		OP_FLUSH  = 2'd2
	} opcode_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic              emit;
		logic              flush;
		logic [DATA_W-1:0] word;
	} pack_res_t;

endpackage
`default_nettype wire

// ===== rtl/bfp_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Field input channel
// Valid/ready channel carrying one field write or flush per transaction.
// ----------------------------------------------------------------------------
interface bfp_in_if import bfp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic [DATA_W-1:0]        raw_bits;
	logic [LEN_W-1:0]         num_bits;
	logic signed [DATA_W-1:0] int_value;
	logic signed [DATA_W-1:0] range_min;
	logic signed [DATA_W-1:0] range_max;

	modport source (
		output valid, opcode, raw_bits, num_bits, int_value, range_min, range_max,
		input  ready
	);

	modport sink (
		input  valid, opcode, raw_bits, num_bits, int_value, range_min, range_max,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/bfp_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Word output channel
// Valid/ready channel carrying one packed word per transaction.
// ----------------------------------------------------------------------------
interface bfp_out_if import bfp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] packed_word;
	logic              flush_word;

	modport source (
		output valid, packed_word, flush_word,
		input  ready
	);

	modport sink (
		input  valid, packed_word, flush_word,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/bfp_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Field decoder
// Turns an incoming transaction into a field length and a masked field value.
// ----------------------------------------------------------------------------
module bfp_decode import bfp_pkg::*; #(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic [OP_W-1:0]          opcode,
	input  logic [DATA_W-1:0]        raw_bits,
	input  logic [LEN_W-1:0]         num_bits,
	input  logic signed [DATA_W-1:0] int_value,
	input  logic signed [DATA_W-1:0] range_min,
	input  logic signed [DATA_W-1:0] range_max,
	output item_t                    item
);

	localparam logic [LEN_W:0] LEN_CAP = (WORD_WIDTH < RAW_LEN_MAX) ?
		(LEN_W+1)'(WORD_WIDTH) : (LEN_W+1)'(RAW_LEN_MAX);

	logic [DATA_W-1:0] diff;
	logic [DATA_W-1:0] diff_m1;
	logic [DATA_W-1:0] offset;
	logic [LEN_W-1:0]  range_len;
	logic [LEN_W:0]    len;
	logic [DATA_W-1:0] val;
	logic [DATA_W-1:0] mask;

	always_comb begin
		diff    = $unsigned(range_max) - $unsigned(range_min);
		diff_m1 = diff - DATA_W'(1);
		offset  = $unsigned(int_value) - $unsigned(range_min);

		range_len = '0;
		for (int i = 0; i < DATA_W; i++) begin
			if (diff_m1[i]) begin
				range_len = LEN_W'(i + 1);
			end
		end
		if (diff < DATA_W'(2)) begin
			range_len = '0;
		end

		case (opcode)
			OP_RAW: begin
				len = (num_bits > LEN_W'(RAW_LEN_MAX)) ? (LEN_W+1)'(RAW_LEN_MAX) : {1'b0, num_bits};
				val = raw_bits;
			end
			OP_RANGED: begin
				len = {1'b0, range_len};
				val = offset;
			end
			default: begin
				len = '0;
				val = '0;
			end
		endcase

		if (len > LEN_CAP) begin
			len = LEN_CAP;
		end

		mask = ~({DATA_W{1'b1}} << len);

		item.op    = opcode;
		item.len   = len[LEN_W-1:0];
		item.value = val & mask;
	end

endmodule
`default_nettype wire

// ===== rtl/bfp_pack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bit packer
// Holds the pending bits and appends one field or flushes in each enabled cycle.
// ----------------------------------------------------------------------------
module bfp_pack import bfp_pkg::*; #(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  item_t     item,
	output pack_res_t res
);

	localparam int CNT_W = $clog2(WORD_WIDTH);
	localparam int SP_W  = ($clog2(WORD_WIDTH + 1) > LEN_W) ? $clog2(WORD_WIDTH + 1) : LEN_W;

	logic [WORD_WIDTH-2:0]        pend_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [WORD_WIDTH-2:0]        pend_d;
	logic [CNT_W-1:0]             cnt_d;

	logic [SP_W-1:0]              space;
	logic [SP_W-1:0]              len_s;
	logic [SP_W-1:0]              rest;
	logic [WORD_WIDTH+DATA_W-1:0] vext;
	logic [WORD_WIDTH-1:0]        v;
	logic [WORD_WIDTH-1:0]        pend_w;
	logic [WORD_WIDTH-1:0]        sum;
	logic [WORD_WIDTH-1:0]        keep;
	logic [WORD_WIDTH-1:0]        word;
	logic [WORD_WIDTH+DATA_W-1:0] wext;

	always_comb begin
		space  = SP_W'(WORD_WIDTH) - SP_W'(cnt_q);
		len_s  = SP_W'(item.len);
		rest   = len_s - space;
		vext   = {{WORD_WIDTH{1'b0}}, item.value};
		v      = vext[WORD_WIDTH-1:0];
		pend_w = {1'b0, pend_q};
		sum    = (pend_w << len_s) | v;
		keep   = v & ~({WORD_WIDTH{1'b1}} << rest);

		pend_d    = pend_q;
		cnt_d     = cnt_q;
		word      = '0;
		res.emit  = 1'b0;
		res.flush = 1'b0;

		case (item.op)
			OP_FLUSH: begin
				word      = pend_w << space;
				res.emit  = 1'b1;
				res.flush = 1'b1;
				pend_d    = '0;
				cnt_d     = '0;
			end
			OP_RAW, OP_RANGED: begin
				if (len_s < space) begin
					pend_d = sum[WORD_WIDTH-2:0];
					cnt_d  = CNT_W'(SP_W'(cnt_q) + len_s);
				end else begin
					word     = (pend_w << space) | (v >> rest);
					pend_d   = keep[WORD_WIDTH-2:0];
					cnt_d    = CNT_W'(rest);
					res.emit = 1'b1;
				end
			end
			default: begin
				pend_d = pend_q;
			end
		endcase

		wext     = {{DATA_W{1'b0}}, word};
		res.word = wext[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (en) begin
			pend_q <= pend_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bit_field_packer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bit field packer core
// Packs variable-width fields, most significant bit first, into words.
// ----------------------------------------------------------------------------
//  Channel  Role    Transaction
//  fields   sink    one raw write, ranged write or flush
//  words    source  one completed word, or the final word of a flush
//
// One transaction is accepted per cycle while ready is high; the input stage
// registers it, and the output register holds a word that it completes. The
// append of a field to the pending bits is a single shift and OR in the
// pending-bit register's loop. Reset clears the pending bits. A full output
// register not taken holds the stage in front of it; input ready deasserts.
// ----------------------------------------------------------------------------
module bit_field_packer_core import bfp_pkg::*; #(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bfp_in_if.sink    fields,
	bfp_out_if.source words
);

	item_t             dec_item;
	item_t             item_s1;
	logic              valid_s1;
	logic              adv;
	pack_res_t         res;
	logic              out_valid_q;
	logic [DATA_W-1:0] word_q;
	logic              flush_q;

	bfp_decode #(
		.WORD_WIDTH (WORD_WIDTH)
	) u_decode (
		.opcode    (fields.opcode),
		.raw_bits  (fields.raw_bits),
		.num_bits  (fields.num_bits),
		.int_value (fields.int_value),
		.range_min (fields.range_min),
		.range_max (fields.range_max),
		.item      (dec_item)
	);

	assign adv          = valid_s1 && (!out_valid_q || words.ready);
	assign fields.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fields.ready) begin
			valid_s1 <= fields.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fields.valid && fields.ready) begin
			item_s1 <= dec_item;
		end
	end

	bfp_pack #(
		.WORD_WIDTH (WORD_WIDTH)
	) u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.emit;
		end else if (words.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			word_q  <= res.word;
			flush_q <= res.flush;
		end
	end

	assign words.valid       = out_valid_q;
	assign words.packed_word = word_q;
	assign words.flush_word  = flush_q;

endmodule
`default_nettype wire
